// ===== hdl/uerf_pkg.sv =====
// Shared types and constants of the ultrasonic echo ranging filter.
// Used by every module of the block; depends on nothing.
package uerf_pkg;

    // input item
    typedef struct packed {
        logic        action;
        logic [1:0]  sensor_index;
        logic        echo_level;
        logic [31:0] time_us;
    } item_t;

    // result item
    typedef struct packed {
        logic [1:0]  out_sensor;
        logic [13:0] distance_q4;
        logic        in_range;
        logic        last_of_round;
    } result_t;

    // classified command from front to back
    typedef struct packed {
        logic        action;
        logic        edge_ok;
        logic [1:0]  sensor_index;
        logic        echo_level;
        logic [31:0] time_us;
    } cmd_t;

    // derived configuration
    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
        logic [8:0]  alpha;
    } cfg_t;

    typedef enum logic [0:0] {
        SEQ_IDLE,
        SEQ_ROUND
    } seq_state_t;

    localparam logic ACT_EDGE   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam int          CFG_IW  = 2;
    localparam int          CFG_DW  = 10;
    localparam logic [1:0]  CFG_MIN   = 2'd0;
    localparam logic [1:0]  CFG_MAX   = 2'd1;
    localparam logic [1:0]  CFG_ALPHA = 2'd2;

    localparam logic [15:0] US_PER_CM   = 16'd58;
    localparam logic [13:0] DIST_MAX    = 14'h3FFF;
    localparam logic [8:0]  ALPHA_ONE   = 9'd256;
    localparam logic [15:0] LO_RESET    = 16'd116;   // 2 cm
    localparam logic [15:0] HI_RESET    = 16'd23200; // 400 cm
    localparam logic [8:0]  ALPHA_RESET = 9'd128;

    // floor(x/29) = (x * RECIP_29) >> RECIP_SHIFT, exact for x < 2^19
    localparam logic [19:0] RECIP_29    = 20'd578525;
    localparam int          RECIP_SHIFT = 24;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_CW    = 3;

endpackage

// ===== hdl/ultrasonic_echo_ranging_filter.sv =====
// Top level of the ultrasonic echo ranging filter: configuration registers,
// front end, back end and result queue. Depends on uerf_pkg and submodules.
//
// Input channel: an item is taken when push is high and full is low. An echo
// edge item (action 0) updates the capture state of one sensor and gives no
// result; a sample item (action 1) gives one result per sensor, in index
// order, the final one flagged last_of_round.
// Result channel: while empty is low the oldest result is on result; it is
// taken when pop is high.
// Configuration: a write is taken when cfg_valid and cfg_ready are high;
// cfg_ready is always high. Index 0 min, 1 max, 2 alpha; others are dropped.
// Flow: an item is registered in the two-entry command queue before the back
// end takes it. An edge item updates its sensor's capture state as it is taken;
// a sample item holds the back end while its sensors issue, one sensor per cycle
// when the result queue has credit, through a three-stage ranging pipeline.
// Stalls: the four-entry result queue fills, the pipeline stops issuing
// sensors by credit, the command queue fills and full goes high.
// Reset clears all capture, width and smoothing state and loads the register
// defaults (2 cm, 400 cm, alpha 128).
module ultrasonic_echo_ranging_filter #(
    parameter int SENSOR_COUNT = 4,
    parameter int TIME_BITS    = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  uerf_pkg::item_t              item,
    output logic                         empty,
    input  logic                         pop,
    output uerf_pkg::result_t            result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [uerf_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [uerf_pkg::CFG_DW-1:0]  cfg_data
);
    import uerf_pkg::*;

    logic [15:0]      lo_reg;
    logic [15:0]      hi_reg;
    logic [8:0]       alpha_reg;
    cfg_t             cfg;
    logic [15:0]      cm_scaled;
    logic [8:0]       alpha_sat;
    logic             cmd_valid;
    logic             cmd_take;
    cmd_t             cmd;
    logic             res_push;
    result_t          res;
    logic [OQ_CW-1:0] oq_count;

    assign cfg_ready = 1'b1;
    // bounds are kept in microseconds of echo width
    assign cm_scaled = {6'd0, cfg_data} * US_PER_CM;
    assign alpha_sat = (cfg_data[8:0] > ALPHA_ONE) ? ALPHA_ONE : cfg_data[8:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg    <= LO_RESET;
            hi_reg    <= HI_RESET;
            alpha_reg <= ALPHA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN:   lo_reg    <= cm_scaled;
                CFG_MAX:   hi_reg    <= cm_scaled;
                CFG_ALPHA: alpha_reg <= alpha_sat;
                default:   lo_reg    <= lo_reg;
            endcase
        end
    end

    assign cfg.lo    = lo_reg;
    assign cfg.hi    = hi_reg;
    assign cfg.alpha = alpha_reg;

    uerf_front #(
        .SENSOR_COUNT(SENSOR_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .push     (push),
        .full     (full),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_take (cmd_take)
    );

    uerf_back #(
        .SENSOR_COUNT(SENSOR_COUNT),
        .TIME_BITS   (TIME_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_take (cmd_take),
        .oq_count (oq_count),
        .res_push (res_push),
        .res      (res)
    );

    uerf_out_queue u_out_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (res_push),
        .wr_data(res),
        .empty  (empty),
        .pop    (pop),
        .rd_data(result),
        .count  (oq_count)
    );

`ifndef SYNTHESIS
    // credit scheme must keep the result queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (oq_count < OQ_CW'(OQ_DEPTH)))
        else $error("result queue overflow");

    a_last_sensor: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.last_of_round) |-> (result.out_sensor == 2'(SENSOR_COUNT - 1)))
        else $error("last_of_round on wrong sensor");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.in_range) |-> (result.distance_q4 == 14'd0))
        else $error("invalid result with nonzero distance");

    // a command is only taken when one is waiting
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from empty queue");
`endif

endmodule

// ===== hdl/uerf_front.sv =====
// Front end: accepts input items, classifies them and holds them in a
// two-entry command queue. Depends on uerf_pkg.
module uerf_front #(
    parameter int SENSOR_COUNT = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  uerf_pkg::item_t item,
    input  logic           push,
    output logic           full,
    output logic           cmd_valid,
    output uerf_pkg::cmd_t cmd,
    input  logic           cmd_take
);
    import uerf_pkg::*;

    cmd_t       q_reg [2];
    logic       head_reg;
    logic       tail_reg;
    logic [1:0] count_reg;
    cmd_t       decoded;
    logic       accept;

    always_comb
    begin
        decoded.action       = item.action;
        decoded.edge_ok      = (32'(item.sensor_index) < 32'(SENSOR_COUNT));
        decoded.sensor_index = item.sensor_index;
        decoded.echo_level   = item.echo_level;
        decoded.time_us      = item.time_us;
    end

    assign full      = (count_reg == 2'd2);
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[head_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[tail_reg] <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                tail_reg <= ~tail_reg;
            end
            if (cmd_take)
            begin
                head_reg <= ~head_reg;
            end
            case ({accept, cmd_take})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== hdl/uerf_back.sv =====
// Back end: edge timing, per-sensor state and the three-stage ranging
// pipeline (bound test and scaling, new-sample weight, blend). Uses uerf_pkg.
module uerf_back #(
    parameter int SENSOR_COUNT = 4,
    parameter int TIME_BITS    = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  uerf_pkg::cfg_t                cfg,
    input  logic                          cmd_valid,
    input  uerf_pkg::cmd_t                cmd,
    output logic                          cmd_take,
    input  logic [uerf_pkg::OQ_CW-1:0]    oq_count,
    output logic                          res_push,
    output uerf_pkg::result_t             res
);
    import uerf_pkg::*;

    localparam int IW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int SW = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam logic [IW-1:0] LAST_IDX = IW'(SENSOR_COUNT - 1);

    logic [SW-1:0]           start_reg  [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] open_reg;
    logic [31:0]             width_reg  [SENSOR_COUNT];
    logic [13:0]             smooth_reg [SENSOR_COUNT];

    seq_state_t state_reg, state_next;
    logic [IW-1:0] idx_reg;

    logic          s1_valid_reg, s1_in_range_reg;
    logic [IW-1:0] s1_idx_reg;
    logic [38:0]   s1_prod_reg;
    logic          s2_valid_reg, s2_in_range_reg;
    logic [IW-1:0] s2_idx_reg;
    logic [22:0]   s2_pa_reg;

    logic          issue, credit_ok, edge_go;
    logic [IW+1:0] eidx_ext;
    logic [IW-1:0] eidx;
    logic [SW-1:0] now, diff;
    logic [31:0]   width_new;

    logic [31:0]   a_w;
    logic          a_in_range;
    logic [18:0]   a_x;
    logic [38:0]   a_prod;
    logic [14:0]   b_nq_raw;
    logic [13:0]   b_nq;
    logic [22:0]   b_pa;
    logic [13:0]   c_sm;
    logic [8:0]    c_inv;
    logic [22:0]   c_ps;
    logic [23:0]   c_sum;
    logic [15:0]   c_q;
    logic [13:0]   c_blend;
    logic [IW+1:0] s2_idx_ext;

    // output queue room left after items already in the pipeline
    assign credit_ok = (oq_count + OQ_CW'(s1_valid_reg) + OQ_CW'(s2_valid_reg))
                       < OQ_CW'(OQ_DEPTH);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (cmd_valid && cmd.action == ACT_SAMPLE)
                begin
                    state_next = SEQ_ROUND;
                end
            end
            SEQ_ROUND:
            begin
                if (credit_ok && idx_reg == LAST_IDX)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_take = 1'b0;
        issue    = 1'b0;
        case (state_reg)
            SEQ_IDLE:  cmd_take = cmd_valid;
            SEQ_ROUND: issue    = credit_ok;
            default:
            begin
                cmd_take = 1'b0;
                issue    = 1'b0;
            end
        endcase
    end

    // edge timing
    assign edge_go  = cmd_take && (cmd.action == ACT_EDGE) && cmd.edge_ok;
    assign eidx_ext = {{IW{1'b0}}, cmd.sensor_index};
    assign eidx     = eidx_ext[IW-1:0];
    assign now      = cmd.time_us[SW-1:0];
    assign diff     = now - start_reg[eidx];

    always_comb
    begin
        width_new         = '0;
        width_new[SW-1:0] = diff;
    end

    // stage A: bound test and width*16/58 = (8*width)/29
    assign a_w        = width_reg[idx_reg];
    assign a_in_range = (a_w > {16'd0, cfg.lo}) && (a_w < {16'd0, cfg.hi});
    assign a_x        = {a_w[15:0], 3'b000};
    assign a_prod     = {20'd0, a_x} * {19'd0, RECIP_29};

    // stage B: saturate and weight the new sample
    assign b_nq_raw = s1_prod_reg[RECIP_SHIFT+14:RECIP_SHIFT];
    assign b_nq     = (b_nq_raw > {1'b0, DIST_MAX}) ? DIST_MAX : b_nq_raw[13:0];
    assign b_pa     = {14'd0, cfg.alpha} * {9'd0, b_nq};

    // stage C: blend with the old value, round half up
    assign c_sm    = smooth_reg[s2_idx_reg];
    assign c_inv   = ALPHA_ONE - cfg.alpha;
    assign c_ps    = {14'd0, c_inv} * {9'd0, c_sm};
    assign c_sum   = {1'b0, s2_pa_reg} + {1'b0, c_ps} + 24'd128;
    assign c_q     = c_sum[23:8];
    assign c_blend = (c_q > {2'b00, DIST_MAX}) ? DIST_MAX : c_q[13:0];

    assign s2_idx_ext        = {2'b00, s2_idx_reg};
    assign res_push          = s2_valid_reg;
    assign res.out_sensor    = s2_idx_ext[1:0];
    assign res.distance_q4   = s2_in_range_reg ? c_blend : 14'd0;
    assign res.in_range      = s2_in_range_reg;
    assign res.last_of_round = (s2_idx_reg == LAST_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                start_reg[i]  <= '0;
                width_reg[i]  <= '0;
                smooth_reg[i] <= '0;
            end
            open_reg     <= '0;
            state_reg    <= SEQ_IDLE;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (edge_go)
            begin
                if (cmd.echo_level)
                begin
                    if (!open_reg[eidx])
                    begin
                        start_reg[eidx] <= now;
                        open_reg[eidx]  <= 1'b1;
                    end
                end
                else
                begin
                    if (open_reg[eidx])
                    begin
                        width_reg[eidx] <= width_new;
                    end
                    open_reg[eidx] <= 1'b0;
                end
            end
            if (issue)
            begin
                width_reg[idx_reg] <= '0;
                idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            end
            if (s2_valid_reg && s2_in_range_reg)
            begin
                smooth_reg[s2_idx_reg] <= c_blend;
            end
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_in_range_reg <= a_in_range;
        s1_idx_reg      <= idx_reg;
        s1_prod_reg     <= a_prod;
        s2_in_range_reg <= s1_in_range_reg;
        s2_idx_reg      <= s1_idx_reg;
        s2_pa_reg       <= b_pa;
    end

endmodule

// ===== hdl/uerf_out_queue.sv =====
// Four-entry result queue between the ranging pipeline and the result port.
// Depends on uerf_pkg.
module uerf_out_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr,
    input  uerf_pkg::result_t          wr_data,
    output logic                       empty,
    input  logic                       pop,
    output uerf_pkg::result_t          rd_data,
    output logic [uerf_pkg::OQ_CW-1:0] count
);
    import uerf_pkg::*;

    localparam int PW = $clog2(OQ_DEPTH);

    result_t          q_reg [OQ_DEPTH];
    logic [PW-1:0]    head_reg;
    logic [PW-1:0]    tail_reg;
    logic [OQ_CW-1:0] count_reg;
    logic             take;

    assign empty   = (count_reg == '0);
    assign take    = pop && !empty;
    assign rd_data = q_reg[head_reg];
    assign count   = count_reg;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[tail_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (take)
            begin
                head_reg <= head_reg + 1'b1;
            end
            case ({wr, take})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Testbench for ultrasonic_echo_ranging_filter: directed table, then random
// pulse and sample traffic checked against an in-bench predictor.
// Depends on uerf_pkg and the RTL of the block only.
module testbench;
    import uerf_pkg::*;

    localparam logic [1:0] CFG_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 12;
    localparam int         CYCLE_LIMIT   = 200000;

    typedef struct {
        logic             is_cfg;
        logic [1:0]       reg_idx;
        logic [9:0]       reg_val;
        item_t            it;
        logic             typed;
        logic [3:0]       exp_valid;
        logic [3:0][13:0] exp_dist;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    item_t      item;
    logic       empty;
    logic       pop;
    result_t    result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [9:0] cfg_data;

    // predictor state and register copies
    logic [9:0]  min_cm;
    logic [9:0]  max_cm;
    logic [8:0]  alpha_w;
    logic [31:0] start_us [4];
    logic        open_f [4];
    logic [31:0] width_us [4];
    logic [13:0] smooth_q4 [4];

    result_t range_q [$];
    dir_row_t dir_rows [$];

    bit calm;
    int errors;
    int items_sent;
    int rounds_sent;
    int results_seen;
    int reg_writes;
    int cycles;
    int hold_left;

    ultrasonic_echo_ranging_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic item_t make_item(input logic act, input logic [1:0] s,
                                        input logic lvl, input logic [31:0] t);
        item_t it;
        it.action       = act;
        it.sensor_index = s;
        it.echo_level   = lvl;
        it.time_us      = t;
        return it;
    endfunction

    function automatic dir_row_t echo_row(input logic [1:0] s, input logic lvl,
                                          input logic [31:0] t);
        dir_row_t r;
        r           = '{default: '0};
        r.it        = make_item(ACT_EDGE, s, lvl, t);
        return r;
    endfunction

    // sample row, expected validity and distance per sensor typed in
    function automatic dir_row_t round_row(input logic [3:0] v, input logic [3:0][13:0] d);
        dir_row_t r;
        r           = '{default: '0};
        r.it        = make_item(ACT_SAMPLE, 2'd0, 1'b0, 32'd0);
        r.typed     = 1'b1;
        r.exp_valid = v;
        r.exp_dist  = d;
        return r;
    endfunction

    function automatic dir_row_t reg_row(input logic [1:0] idx, input logic [9:0] val);
        dir_row_t r;
        r         = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Works out the results of one accepted item and queues them.
    task automatic predict_item(input item_t it, input logic use_typed,
                                input logic [3:0] tv, input logic [3:0][13:0] td);
        int              s;
        longint unsigned w64;
        longint unsigned lo64;
        longint unsigned hi64;
        longint unsigned a64;
        longint unsigned nq;
        longint unsigned blend;
        result_t         r;
        s = int'(it.sensor_index);
        if (it.action == ACT_EDGE) begin
            if (it.echo_level) begin
                if (!open_f[s]) begin
                    start_us[s] = it.time_us;
                    open_f[s]   = 1'b1;
                end
            end
            else begin
                if (open_f[s])
                    width_us[s] = it.time_us - start_us[s];
                open_f[s] = 1'b0;
            end
        end
        else begin
            a64  = 64'((alpha_w > ALPHA_ONE) ? ALPHA_ONE : alpha_w);
            lo64 = 64'(min_cm);
            lo64 = lo64 * US_PER_CM;
            hi64 = 64'(max_cm);
            hi64 = hi64 * US_PER_CM;
            for (int k = 0; k < 4; k++) begin
                w64             = 64'(width_us[k]);
                r.out_sensor    = k[1:0];
                r.distance_q4   = '0;
                r.in_range      = 1'b0;
                r.last_of_round = (k == 3);
                if (w64 > lo64 && w64 < hi64) begin
                    nq = (w64 * 16) / US_PER_CM;
                    if (nq > DIST_MAX)
                        nq = 64'(DIST_MAX);
                    blend = (a64 * nq + (ALPHA_ONE - a64) * smooth_q4[k] + 128) >> 8;
                    if (blend > DIST_MAX)
                        blend = 64'(DIST_MAX);
                    smooth_q4[k]  = blend[13:0];
                    r.distance_q4 = blend[13:0];
                    r.in_range    = 1'b1;
                end
                width_us[k] = '0;
                if (use_typed) begin
                    r.in_range    = tv[k];
                    r.distance_q4 = td[k];
                end
                range_q.push_back(r);
            end
            rounds_sent++;
        end
    endtask

    task automatic send_item(input item_t it, input logic use_typed = 1'b0,
                             input logic [3:0] tv = '0, input logic [3:0][13:0] td = '0);
        cfg_valid <= 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
        predict_item(it, use_typed, tv, td);
        items_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MIN:   min_cm  = val;
            CFG_MAX:   max_cm  = val;
            CFG_ALPHA: alpha_w = val[8:0];
            default:   ;
        endcase
        reg_writes++;
    endtask

    // stop sending, wait out every queued result, then let the pipeline settle
    task automatic drain();
        push <= 1'b0;
        while (range_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int n, input logic [9:0] mn, input logic [9:0] mx,
                                input logic [9:0] al);
        int          sent;
        int unsigned lo_us;
        int unsigned hi_us;
        int unsigned w;
        int unsigned t0;
        logic [1:0]  s;
        drain();
        write_reg(CFG_MIN, mn);
        write_reg(CFG_MAX, mx);
        write_reg(CFG_ALPHA, al);
        write_reg(CFG_UNUSED, 10'($urandom_range(0, 1023)));
        lo_us = mn * 58;
        hi_us = mx * 58;
        sent  = 0;
        while (sent < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    // one complete echo pulse, width mostly around the bounds
                    s = 2'($urandom_range(0, 3));
                    case ($urandom_range(0, 7))
                        0:       w = lo_us;
                        1:       w = lo_us + 1;
                        2:       w = hi_us - 1;
                        3:       w = hi_us;
                        default: w = $urandom_range(lo_us > 60 ? lo_us - 60 : 0, hi_us + 60);
                    endcase
                    t0 = $urandom;
                    send_item(make_item(ACT_EDGE, s, 1'b1, t0));
                    send_item(make_item(ACT_EDGE, s, 1'b0, t0 + w));
                    sent += 2;
                end
                6, 7: begin
                    send_item(make_item(ACT_SAMPLE, 2'($urandom_range(0, 3)),
                                        1'($urandom_range(0, 1)), $urandom));
                    sent++;
                end
                default: begin
                    // stray edge: double rise, orphan fall or random time
                    send_item(make_item(ACT_EDGE, 2'($urandom_range(0, 3)),
                                        1'($urandom_range(0, 1)), $urandom));
                    sent++;
                end
            endcase
        end
    endtask

    // result side: random stall bursts, none once calm
    always @(posedge clk)
    begin
        if (!rst_n) begin
            pop       <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left > 0) begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!calm && $urandom_range(0, 5) == 0) begin
            pop       <= 1'b0;
            hold_left <= int'($urandom_range(0, 10));
        end
        else begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && pop && !empty) begin
            if (range_q.size() == 0) begin
                $error("result with nothing expected: sensor %0d distance %0d",
                       result.out_sensor, result.distance_q4);
                errors = errors + 1;
            end
            else begin
                want = range_q.pop_front();
                results_seen++;
                if (result.out_sensor !== want.out_sensor) begin
                    $error("out_sensor: expected %0d, got %0d",
                           want.out_sensor, result.out_sensor);
                    errors = errors + 1;
                end
                if (result.distance_q4 !== want.distance_q4) begin
                    $error("distance_q4: expected %0d, got %0d",
                           want.distance_q4, result.distance_q4);
                    errors = errors + 1;
                end
                if (result.in_range !== want.in_range) begin
                    $error("in_range: expected %0d, got %0d", want.in_range, result.in_range);
                    errors = errors + 1;
                end
                if (result.last_of_round !== want.last_of_round) begin
                    $error("last_of_round: expected %0d, got %0d",
                           want.last_of_round, result.last_of_round);
                    errors = errors + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", range_q.size());
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        clk       = 1'b0;
        rst_n     = 1'b0;
        push      = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        errors    = 0;
        cycles    = 0;
        min_cm    = 10'd2;
        max_cm    = 10'd400;
        alpha_w   = 9'd128;
        for (int k = 0; k < 4; k++) begin
            start_us[k]  = '0;
            open_f[k]    = 1'b0;
            width_us[k]  = '0;
            smooth_q4[k] = '0;
        end

        // reset defaults: nothing captured yet, every sensor invalid
        dir_rows.push_back(round_row(4'b0000, '0));
        dir_rows.push_back(echo_row(2'd0, 1'b1, 32'd1000));
        dir_rows.push_back(echo_row(2'd0, 1'b0, 32'd1117));            // 117 us, just in
        dir_rows.push_back(echo_row(2'd1, 1'b1, 32'hFFFF_FFF0));
        dir_rows.push_back(echo_row(2'd1, 1'b0, 32'h0000_0010));       // wraps, 32 us
        dir_rows.push_back(echo_row(2'd2, 1'b1, 32'd500));
        dir_rows.push_back(echo_row(2'd2, 1'b1, 32'd900));             // open already, kept
        dir_rows.push_back(echo_row(2'd2, 1'b0, 32'd616));             // exactly on min
        dir_rows.push_back(echo_row(2'd3, 1'b0, 32'd5000));            // no capture open
        dir_rows.push_back(round_row(4'b0001, {14'd0, 14'd0, 14'd0, 14'd16}));
        dir_rows.push_back(echo_row(2'd3, 1'b1, 32'd0));
        dir_rows.push_back(echo_row(2'd3, 1'b0, 32'd23199));           // just under max
        dir_rows.push_back(echo_row(2'd2, 1'b1, 32'd0));
        dir_rows.push_back(echo_row(2'd2, 1'b0, 32'd23200));           // exactly on max
        dir_rows.push_back(echo_row(2'd0, 1'b1, 32'hFFFF_FFFF));
        dir_rows.push_back(echo_row(2'd0, 1'b0, 32'hFFFF_FFFE));       // widest pulse
        dir_rows.push_back(round_row(4'b1000, {14'd3200, 14'd0, 14'd0, 14'd0}));
        // widest window, alpha above one
        dir_rows.push_back(reg_row(CFG_MIN, 10'd0));
        dir_rows.push_back(reg_row(CFG_MAX, 10'd1023));
        dir_rows.push_back(reg_row(CFG_ALPHA, 10'd300));
        dir_rows.push_back(reg_row(CFG_UNUSED, 10'h3FF));
        dir_rows.push_back(echo_row(2'd0, 1'b1, 32'd7));
        dir_rows.push_back(echo_row(2'd0, 1'b0, 32'd59340));           // 59333 us
        dir_rows.push_back(round_row(4'b0001, {14'd0, 14'd0, 14'd0, 14'd16367}));
        // alpha zero holds the old value
        dir_rows.push_back(reg_row(CFG_ALPHA, 10'd0));
        dir_rows.push_back(echo_row(2'd0, 1'b1, 32'd0));
        dir_rows.push_back(echo_row(2'd0, 1'b0, 32'd117));
        dir_rows.push_back(round_row(4'b0001, {14'd0, 14'd0, 14'd0, 14'd16367}));
        // inverted bounds
        dir_rows.push_back(reg_row(CFG_MIN, 10'd1023));
        dir_rows.push_back(reg_row(CFG_MAX, 10'd0));
        dir_rows.push_back(echo_row(2'd1, 1'b1, 32'd100));
        dir_rows.push_back(echo_row(2'd1, 1'b0, 32'd5900));
        dir_rows.push_back(round_row(4'b0000, '0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                if (i == 0 || !dir_rows[i - 1].is_cfg)
                    drain();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else begin
                send_item(dir_rows[i].it, dir_rows[i].typed,
                          dir_rows[i].exp_valid, dir_rows[i].exp_dist);
            end
        end

        random_phase(70, 10'd0, 10'd1023, 10'd256);
        random_phase(70, 10'($urandom_range(0, 120)), 10'($urandom_range(150, 1023)),
                     10'($urandom_range(0, 1023)));
        random_phase(40, 10'd1023, 10'd0, 10'd0);
        random_phase(70, 10'($urandom_range(0, 60)), 10'($urandom_range(60, 400)),
                     10'($urandom_range(257, 511) | ($urandom_range(0, 1) << 9)));
        random_phase(60, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                     10'($urandom_range(0, 1023)));
        calm = 1'b1;
        random_phase(70, 10'd2, 10'd400, 10'd128);
        drain();

        $display("covered %0d items with %0d sample rounds, %0d results compared",
                 items_sent, rounds_sent, results_seen);
        $display("over %0d register writes: bounds, inverted window, alpha 0 to above 256",
                 reg_writes);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/uerf_pkg.sv
hdl/uerf_front.sv
hdl/uerf_back.sv
hdl/uerf_out_queue.sv
hdl/ultrasonic_echo_ranging_filter.sv
sim/testbench.sv
